### sv/oxygen_sensor_signal_shaper_assert.svh
// assertion macros used by the oxygen sensor signal shaper core
`ifndef OXYGEN_SENSOR_SIGNAL_SHAPER_ASSERT_SVH
`define OXYGEN_SENSOR_SIGNAL_SHAPER_ASSERT_SVH

// plain clocked property, disabled while in reset
`define OSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define OSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  `OSS_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define OSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `OSS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### sv/oss_pkg.sv
// shared types and constants of the oxygen sensor signal shaper
package oss_pkg;

  localparam int unsigned LevelW = 12;
  localparam int unsigned TickW  = 24;
  localparam int unsigned ProdW  = TickW + 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PAddrW = 5;

  localparam int unsigned UpStep        = 8;
  localparam int unsigned DownStep      = 8;
  localparam int unsigned MidStep       = 4;
  localparam int unsigned RefPctSame    = 50;
  localparam int unsigned RefPctTwoOnly = 50;
  localparam int unsigned RefPctOneOnly = 50;
  localparam int unsigned PctScale      = 100;
  localparam int unsigned StartDuration = 500;

  typedef enum logic [1:0] {
    MIX_UNDEF = 2'd0,
    MIX_LEAN  = 2'd1,
    MIX_RICH  = 2'd2
  } mix_e;

  typedef enum logic [2:0] {
    MODE_REF    = 3'd0,
    MODE_CATOFF = 3'd1,
    MODE_UP     = 3'd2,
    MODE_DOWN   = 3'd3,
    MODE_MID    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    PH_WAIT        = 3'd0,
    PH_LEAN_START  = 3'd1,
    PH_RICH_START  = 3'd2,
    PH_LEAN_TIME   = 3'd3,
    PH_RICH_TSTART = 3'd4,
    PH_RICH_TIME   = 3'd5,
    PH_BOOST_ENTRY = 3'd6,
    PH_BOOST_HOLD  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    REG_RICH_TH    = 3'd0,
    REG_LEAN_TH    = 3'd1,
    REG_DEFAULT    = 3'd2,
    REG_MIN        = 3'd3,
    REG_NORMAL_MAX = 3'd4,
    REG_BOOST_MAX  = 3'd5,
    REG_LEAN_TO    = 3'd6,
    REG_RICH_PWR   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] rich_threshold;
    logic [LevelW-1:0] lean_threshold;
    logic [LevelW-1:0] default_level;
    logic [LevelW-1:0] min_level;
    logic [LevelW-1:0] normal_max_level;
    logic [LevelW-1:0] boost_max_level;
    logic [TickW-1:0]  lean_timeout_ticks;
    logic [TickW-1:0]  rich_power_ticks;
  } cfg_t;

endpackage

### sv/oss_intf.sv
// channel interfaces: tick input and result output
interface oss_tick_if;
  import oss_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] sensor_level;
  logic              switch_one;
  logic              switch_two;

  modport source (output valid, sensor_level, switch_one, switch_two, input ready);
  modport sink (input valid, sensor_level, switch_one, switch_two, output ready);
endinterface

interface oss_result_if;
  import oss_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] drive_level;
  logic [1:0]        mix_class;
  logic [2:0]        drive_mode;

  modport source (output valid, drive_level, mix_class, drive_mode, input ready);
  modport sink (input valid, drive_level, mix_class, drive_mode, output ready);
endinterface

### sv/oss_apb_regs.sv
// apb configuration register bank
module oss_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oss_pkg::PAddrW-1:0] paddr,
  input  logic [oss_pkg::DataW-1:0]  pwdata,
  output logic [oss_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output oss_pkg::cfg_t              cfg_o
);
  import oss_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[PAddrW-1:2]);
  assign cfg_o  = cfg_q;

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rich_threshold     <= LevelW'(2048);
      cfg_q.lean_threshold     <= LevelW'(1024);
      cfg_q.default_level      <= LevelW'(1800);
      cfg_q.min_level          <= '0;
      cfg_q.normal_max_level   <= LevelW'(3000);
      cfg_q.boost_max_level    <= LevelW'(4000);
      cfg_q.lean_timeout_ticks <= TickW'(10000);
      cfg_q.rich_power_ticks   <= TickW'(10000);
    end else if (wr_en) begin
      case (idx)
        REG_RICH_TH:    cfg_q.rich_threshold     <= pwdata[LevelW-1:0];
        REG_LEAN_TH:    cfg_q.lean_threshold     <= pwdata[LevelW-1:0];
        REG_DEFAULT:    cfg_q.default_level      <= pwdata[LevelW-1:0];
        REG_MIN:        cfg_q.min_level          <= pwdata[LevelW-1:0];
        REG_NORMAL_MAX: cfg_q.normal_max_level   <= pwdata[LevelW-1:0];
        REG_BOOST_MAX:  cfg_q.boost_max_level    <= pwdata[LevelW-1:0];
        REG_LEAN_TO:    cfg_q.lean_timeout_ticks <= pwdata[TickW-1:0];
        REG_RICH_PWR:   cfg_q.rich_power_ticks   <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_RICH_TH:    prdata = DataW'(cfg_q.rich_threshold);
      REG_LEAN_TH:    prdata = DataW'(cfg_q.lean_threshold);
      REG_DEFAULT:    prdata = DataW'(cfg_q.default_level);
      REG_MIN:        prdata = DataW'(cfg_q.min_level);
      REG_NORMAL_MAX: prdata = DataW'(cfg_q.normal_max_level);
      REG_BOOST_MAX:  prdata = DataW'(cfg_q.boost_max_level);
      REG_LEAN_TO:    prdata = DataW'(cfg_q.lean_timeout_ticks);
      REG_RICH_PWR:   prdata = DataW'(cfg_q.rich_power_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

### sv/oss_core.sv
// phase timing machine, share test and drive level update for one tick
`include "oxygen_sensor_signal_shaper_assert.svh"

module oss_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  oss_pkg::cfg_t              cfg_i,
  input  logic                       step_i,
  input  logic [oss_pkg::LevelW-1:0] sensor_level_i,
  input  logic                       switch_one_i,
  input  logic                       switch_two_i,
  output logic [oss_pkg::LevelW-1:0] drive_level_o,
  output oss_pkg::mix_e              mix_class_o,
  output oss_pkg::mode_e             drive_mode_o
);
  import oss_pkg::*;

  localparam logic [TickW-1:0] TickMax = '1;

  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;
  logic [TickW-1:0]  lean_dur_q, lean_dur_d;
  logic [TickW-1:0]  rich_dur_q, rich_dur_d;
  mode_e             mode_q, mode_d;
  logic              boost_q, boost_d;
  logic [LevelW-1:0] level_q, level_d;

  mix_e              mix;
  logic [TickW-1:0]  el_inc;
  logic              lean_over, rich_over;
  logic [TickW-1:0]  sh_lean, sh_rich;
  logic [TickW:0]    sh_sum;
  logic [ProdW-1:0]  sh_lhs, sh_rhs;
  logic [7:0]        pct;
  mode_e             share_mode;

  // classify sample, rich wins on overlap
  always_comb begin
    if (sensor_level_i >= cfg_i.rich_threshold) begin
      mix = MIX_RICH;
    end else if (sensor_level_i <= cfg_i.lean_threshold) begin
      mix = MIX_LEAN;
    end else begin
      mix = MIX_UNDEF;
    end
  end

  // saturating timer increment and timeouts
  assign el_inc    = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + TickW'(1);
  assign lean_over = el_inc > cfg_i.lean_timeout_ticks;
  assign rich_over = el_inc > cfg_i.rich_power_ticks;

  // rich share test by cross multiplication
  always_comb begin
    if (switch_one_i == switch_two_i) begin
      pct = 8'(RefPctSame);
    end else if (switch_two_i) begin
      pct = 8'(RefPctTwoOnly);
    end else begin
      pct = 8'(RefPctOneOnly);
    end
  end

  assign sh_lean = (phase_q == PH_LEAN_TIME) ? el_inc : lean_dur_q;
  assign sh_rich = (phase_q == PH_RICH_TIME) ? el_inc : rich_dur_q;
  assign sh_sum  = {1'b0, sh_lean} + {1'b0, sh_rich};
  assign sh_lhs  = ProdW'(sh_rich) * ProdW'(PctScale);
  assign sh_rhs  = ProdW'(sh_sum) * ProdW'(pct);
  assign share_mode = ((sh_sum != '0) && (sh_lhs >= sh_rhs)) ? MODE_UP : MODE_DOWN;

  // phase next state
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_WAIT: begin
        if (mix == MIX_LEAN) begin
          phase_d = PH_LEAN_START;
        end else if (mix == MIX_RICH) begin
          phase_d = PH_RICH_START;
        end
      end
      PH_LEAN_START:  phase_d = PH_LEAN_TIME;
      PH_RICH_START:  phase_d = PH_RICH_TSTART;
      PH_LEAN_TIME: begin
        if (lean_over || mix == MIX_UNDEF) begin
          phase_d = PH_WAIT;
        end else if (mix == MIX_RICH) begin
          phase_d = PH_RICH_TSTART;
        end
      end
      PH_RICH_TSTART: phase_d = PH_RICH_TIME;
      PH_RICH_TIME: begin
        if (rich_over) begin
          phase_d = PH_BOOST_ENTRY;
        end else if (mix == MIX_LEAN) begin
          phase_d = PH_LEAN_START;
        end else if (mix == MIX_UNDEF) begin
          phase_d = PH_WAIT;
        end
      end
      PH_BOOST_ENTRY: phase_d = PH_BOOST_HOLD;
      PH_BOOST_HOLD: begin
        if (mix == MIX_LEAN) begin
          phase_d = PH_LEAN_START;
        end
      end
      default: phase_d = PH_WAIT;
    endcase
  end

  // phase outputs: timer, durations, mode and ceiling select
  always_comb begin
    elapsed_d  = elapsed_q;
    lean_dur_d = lean_dur_q;
    rich_dur_d = rich_dur_q;
    mode_d     = mode_q;
    boost_d    = boost_q;
    case (phase_q)
      PH_LEAN_START, PH_RICH_TSTART: elapsed_d = '0;
      PH_LEAN_TIME: begin
        elapsed_d = el_inc;
        if (lean_over) begin
          mode_d = MODE_CATOFF;
        end else if (mix != MIX_LEAN) begin
          lean_dur_d = el_inc;
          mode_d     = share_mode;
          if (mix == MIX_RICH) begin
            boost_d = 1'b0;
          end
        end
      end
      PH_RICH_TIME: begin
        elapsed_d = el_inc;
        if (!rich_over && mix != MIX_RICH) begin
          rich_dur_d = el_inc;
          boost_d    = 1'b0;
          mode_d     = share_mode;
        end
      end
      PH_BOOST_ENTRY: begin
        rich_dur_d = elapsed_q;
        boost_d    = 1'b1;
        mode_d     = MODE_UP;
      end
      PH_BOOST_HOLD: begin
        if (mix == MIX_LEAN) begin
          mode_d  = MODE_DOWN;
          boost_d = 1'b0;
        end else if (mix == MIX_UNDEF) begin
          mode_d = MODE_MID;
        end else begin
          mode_d = MODE_UP;
        end
      end
      default: ;
    endcase
  end

  // drive level update following the new mode
  always_comb begin
    logic [LevelW:0] lv, def, top, lo;
    lv  = {1'b0, level_q};
    def = {1'b0, cfg_i.default_level};
    top = {1'b0, boost_d ? cfg_i.boost_max_level : cfg_i.normal_max_level};
    lo  = {1'b0, cfg_i.min_level};
    level_d = level_q;
    case (mode_d)
      MODE_REF:    level_d = cfg_i.default_level;
      MODE_CATOFF: level_d = cfg_i.min_level;
      MODE_UP: begin
        if (lv + (LevelW+1)'(UpStep) <= top) begin
          level_d = LevelW'(lv + (LevelW+1)'(UpStep));
        end
      end
      MODE_DOWN: begin
        if (lv >= lo + (LevelW+1)'(DownStep)) begin
          level_d = LevelW'(lv - (LevelW+1)'(DownStep));
        end
      end
      default: begin
        if (lv > def) begin
          level_d = (lv - def < (LevelW+1)'(MidStep)) ? cfg_i.default_level
                                                     : LevelW'(lv - (LevelW+1)'(MidStep));
        end else if (lv < def) begin
          level_d = (def - lv < (LevelW+1)'(MidStep)) ? cfg_i.default_level
                                                     : LevelW'(lv + (LevelW+1)'(MidStep));
        end
      end
    endcase
  end

  // state registers, advanced once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      elapsed_q  <= '0;
      lean_dur_q <= TickW'(StartDuration);
      rich_dur_q <= TickW'(StartDuration);
      mode_q     <= MODE_REF;
      boost_q    <= 1'b0;
      level_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      lean_dur_q <= lean_dur_d;
      rich_dur_q <= rich_dur_d;
      mode_q     <= mode_d;
      boost_q    <= boost_d;
      level_q    <= level_d;
    end
  end

  assign drive_level_o = level_d;
  assign mix_class_o   = mix;
  assign drive_mode_o  = mode_d;

  // checks
  `OSS_ASSERT_NEXT(a_timer_restart, step_i && phase_q == PH_LEAN_START, elapsed_q == '0, "timer not cleared at lean start")
  `OSS_ASSERT_NEXT(a_boost_entry, step_i && phase_q == PH_BOOST_ENTRY, boost_q && mode_q == MODE_UP && phase_q == PH_BOOST_HOLD, "boost entry failed")
  `OSS_ASSERT_IMPL(a_catoff_src, step_i && mode_d == MODE_CATOFF && mode_q != MODE_CATOFF, phase_q == PH_LEAN_TIME, "catalyst off outside lean timing")
  `OSS_ASSERT_IMPL(a_up_monotonic, step_i && mode_d == MODE_UP, level_d >= level_q, "level fell in up mode")
  `OSS_ASSERT_IMPL(a_down_monotonic, step_i && mode_d == MODE_DOWN, level_d <= level_q, "level rose in down mode")

endmodule

### sv/oxygen_sensor_signal_shaper.sv
// top level of the oxygen sensor signal shaper
//
// Usage: each transaction on tick_i is one sensor tick carrying a 12-bit
// sensor_level sample and the two reference switches. For every tick one
// transaction leaves on result_o with the new drive_level, the tick's
// mix_class and the drive_mode after the tick. Both channels use
// valid/ready. Thresholds, levels and phase timeouts sit in an APB register
// bank (byte address 4*index); write it only while no tick is in flight.
// Path: an accepted tick passes the input register, then the core logic,
// then the result register.
// Throughput: one tick per cycle while result_o is taken; phase machine
// and level update are one compare/add/multiply pass between the registers.
// Stall: when result_o is not taken the result register holds, the input
// register still takes one more tick, and tick_i.ready then drops.
// Reset: phase machine waits for a classified sample, timer zero, both
// durations 500 ticks, reference mode, normal ceiling, drive level zero.
module oxygen_sensor_signal_shaper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  oss_tick_if.sink                   tick_i,
  oss_result_if.source               result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [oss_pkg::PAddrW-1:0] paddr,
  input  logic [oss_pkg::DataW-1:0]  pwdata,
  output logic [oss_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import oss_pkg::*;

  cfg_t              cfg;
  logic              in_vld_q;
  logic [LevelW-1:0] in_level_q;
  logic              in_sw1_q, in_sw2_q;
  logic              out_vld_q;
  logic [LevelW-1:0] out_level_q;
  mix_e              out_mix_q;
  mode_e             out_mode_q;
  logic              advance;
  logic [LevelW-1:0] core_level;
  mix_e              core_mix;
  mode_e             core_mode;

  oss_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake: process when the result slot is free or being drained
  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign tick_i.ready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_vld_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.ready && tick_i.valid) begin
      in_level_q <= tick_i.sensor_level;
      in_sw1_q   <= tick_i.switch_one;
      in_sw2_q   <= tick_i.switch_two;
    end
  end

  oss_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .step_i         (advance),
    .sensor_level_i (in_level_q),
    .switch_one_i   (in_sw1_q),
    .switch_two_i   (in_sw2_q),
    .drive_level_o  (core_level),
    .mix_class_o    (core_mix),
    .drive_mode_o   (core_mode)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q <= core_level;
      out_mix_q   <= core_mix;
      out_mode_q  <= core_mode;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.drive_level = out_level_q;
  assign result_o.mix_class   = out_mix_q;
  assign result_o.drive_mode  = out_mode_q;

endmodule
